// File: hw/rtl/pfc_pkg.sv
// Shared types, codes and helper functions of the Playfair cipher core.
`default_nettype none
package pfc_pkg;

  localparam logic [2:0] ACT_BEGIN = 3'd0;
  localparam logic [2:0] ACT_KEY   = 3'd1;
  localparam logic [2:0] ACT_DONE  = 3'd2;
  localparam logic [2:0] ACT_TEXT  = 3'd3;
  localparam logic [2:0] ACT_END   = 3'd4;

  localparam logic [4:0] IDX_I    = 5'd8;
  localparam logic [4:0] IDX_J    = 5'd9;
  localparam logic [4:0] IDX_X    = 5'd23;
  localparam logic [4:0] IDX_LAST = 5'd25;
  localparam logic [4:0] SQ_CELLS = 5'd25;
  localparam logic [6:0] ASCII_A  = 7'd65;

  typedef struct packed {
    logic clr_key;
    logic key_place;
    logic walk_ld;
    logic walk_step;
    logic hold_txt;
    logic pair_txt;
    logic pair_end;
    logic rd_b;
    logic calc;
    logic rd_q2;
    logic grab_l2;
    logic sel_l2;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       letter_ok;
    logic       sq_full;
    logic       held_v;
    logic       walk_last;
  } sts_t;

  // Returns {valid, index} with J folded onto I.
  function automatic logic [5:0] letter_idx(input logic [7:0] b);
    logic [7:0] v;
    logic [4:0] idx;
    logic       ok;
    begin
      v   = 8'd0;
      ok  = 1'b0;
      if (b >= 8'd97 && b <= 8'd122) begin
        v  = b - 8'd97;
        ok = 1'b1;
      end else if (b >= 8'd65 && b <= 8'd90) begin
        v  = b - 8'd65;
        ok = 1'b1;
      end
      idx = v[4:0];
      if (idx == IDX_J) begin
        idx = IDX_I;
      end
      letter_idx = {ok, idx};
    end
  endfunction

  function automatic logic [2:0] row_of(input logic [4:0] p);
    begin
      if (p >= 5'd20) begin
        row_of = 3'd4;
      end else if (p >= 5'd15) begin
        row_of = 3'd3;
      end else if (p >= 5'd10) begin
        row_of = 3'd2;
      end else if (p >= 5'd5) begin
        row_of = 3'd1;
      end else begin
        row_of = 3'd0;
      end
    end
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [2:0] r;
    logic [4:0] base;
    begin
      r      = row_of(p);
      base   = {r[2:0], 2'b00} + {2'b00, r};
      col_of = 3'(p - base);
    end
  endfunction

  function automatic logic [2:0] step5(input logic [2:0] v, input logic dec);
    begin
      if (dec) begin
        step5 = (v == 3'd0) ? 3'd4 : 3'(v - 3'd1);
      end else begin
        step5 = (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
      end
    end
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    begin
      cell_of = {r, 2'b00} + {2'b00, r} + {2'b00, c};
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pfc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hw/rtl/pfc_ctrl.sv
// Controller state machine that sequences key fill, pair lookup and output.
`default_nettype none
module pfc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic               out_tlast,
  input  wire pfc_pkg::sts_t sts,
  output pfc_pkg::cmd_t      cmd
);
  import pfc_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_FILL = 10'b0000000010,
    ST_PA   = 10'b0000000100,
    ST_PB   = 10'b0000001000,
    ST_PC   = 10'b0000010000,
    ST_SA   = 10'b0000100000,
    ST_SB   = 10'b0001000000,
    ST_SC   = 10'b0010000000,
    ST_EM1  = 10'b0100000000,
    ST_EM2  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;
  logic   txt_pair;
  logic   end_pair;

  assign in_tready  = (state_r == ST_IDLE);
  assign take       = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_EM1) || (state_r == ST_EM2);
  assign out_tlast  = (state_r == ST_EM2);

  assign txt_pair = take && (sts.act == ACT_TEXT) && sts.sq_full && sts.letter_ok
                    && sts.held_v;
  assign end_pair = take && (sts.act == ACT_END) && sts.sq_full && sts.held_v;

  always_comb begin
    cmd           = '0;
    cmd.clr_key   = take && (sts.act == ACT_BEGIN);
    cmd.key_place = take && (sts.act == ACT_KEY) && sts.letter_ok;
    cmd.walk_ld   = take && (sts.act == ACT_DONE);
    cmd.walk_step = (state_r == ST_FILL);
    cmd.hold_txt  = take && (sts.act == ACT_TEXT) && sts.sq_full && sts.letter_ok
                    && !sts.held_v;
    cmd.pair_txt  = txt_pair;
    cmd.pair_end  = end_pair;
    cmd.rd_b      = (state_r == ST_PB);
    cmd.calc      = (state_r == ST_PC);
    cmd.rd_q2     = (state_r == ST_SB);
    cmd.grab_l2   = (state_r == ST_SC);
    cmd.sel_l2    = (state_r == ST_EM2);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.walk_ld) begin
          state_nxt = ST_FILL;
        end else if (txt_pair || end_pair) begin
          state_nxt = ST_PA;
        end
      end
      ST_FILL: begin
        if (sts.walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PA: state_nxt = ST_PB;
      ST_PB: state_nxt = ST_PC;
      ST_PC: state_nxt = ST_SA;
      ST_SA: state_nxt = ST_SB;
      ST_SB: state_nxt = ST_SC;
      ST_SC: state_nxt = ST_EM1;
      ST_EM1: begin
        if (out_tready) begin
          state_nxt = ST_EM2;
        end
      end
      ST_EM2: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pfc_dpath.sv
// Datapath with key square, letter places, held letter and pair lookup.
`default_nettype none
module pfc_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [2:0]    action,
  input  wire logic [7:0]    data_byte,
  input  wire logic          decrypt_mode,
  input  wire pfc_pkg::cmd_t cmd,
  output pfc_pkg::sts_t      sts,
  output logic [6:0]         letter
);
  import pfc_pkg::*;

  logic [25:0] used_r, used_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic [4:0]  walk_r, walk_nxt;
  logic [4:0]  held_r, held_nxt;
  logic        held_v_r, held_v_nxt;
  logic [4:0]  a_r, a_nxt;
  logic [4:0]  b_r, b_nxt;
  logic [4:0]  p1_r;
  logic [4:0]  q1_r, q2_r;
  logic [4:0]  l1_r, l2_r;

  logic [5:0]  dec;
  logic [4:0]  kidx;
  logic        repeat_hit;
  logic        plc_en;
  logic [4:0]  plc_idx;
  logic        plc_we;
  logic [4:0]  place_q;
  logic [4:0]  sq_q;
  logic [4:0]  place_ra;
  logic [4:0]  sq_ra;
  logic [2:0]  r1, c1, r2, c2;
  logic [4:0]  q1_nxt, q2_nxt;
  logic [4:0]  l_sel;

  assign dec        = letter_idx(data_byte);
  assign kidx       = dec[4:0];
  assign repeat_hit = !decrypt_mode && (kidx == held_r);

  assign sts.act       = action;
  assign sts.letter_ok = dec[5];
  assign sts.sq_full   = (fill_r == SQ_CELLS);
  assign sts.held_v    = held_v_r;
  assign sts.walk_last = (walk_r == IDX_LAST);

  assign plc_en  = cmd.key_place || cmd.walk_step;
  assign plc_idx = cmd.walk_step ? walk_r : kidx;
  assign plc_we  = plc_en && (fill_r < SQ_CELLS) && !used_r[plc_idx];

  pfc_ram #(.WIDTH(5), .DEPTH(25)) u_sq_ram (
    .clk   (clk),
    .we    (plc_we),
    .waddr (fill_r),
    .wdata (plc_idx),
    .raddr (sq_ra),
    .rdata (sq_q)
  );

  pfc_ram #(.WIDTH(5), .DEPTH(26)) u_place_ram (
    .clk   (clk),
    .we    (plc_we),
    .waddr (plc_idx),
    .wdata (fill_r),
    .raddr (place_ra),
    .rdata (place_q)
  );

  assign place_ra = cmd.rd_b ? b_r : a_r;
  assign sq_ra    = cmd.rd_q2 ? q2_r : q1_r;

  always_comb begin
    used_nxt   = used_r;
    fill_nxt   = fill_r;
    walk_nxt   = walk_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    if (plc_we) begin
      used_nxt[plc_idx] = 1'b1;
      fill_nxt          = fill_r + 5'd1;
    end
    if (cmd.walk_ld) begin
      walk_nxt = 5'd0;
    end else if (cmd.walk_step && walk_r != IDX_LAST) begin
      walk_nxt = walk_r + 5'd1;
    end
    if (cmd.clr_key) begin
      used_nxt        = '0;
      used_nxt[IDX_J] = 1'b1;
      fill_nxt        = 5'd0;
      held_nxt        = 5'd0;
      held_v_nxt      = 1'b0;
    end
    if (cmd.hold_txt) begin
      held_nxt   = kidx;
      held_v_nxt = 1'b1;
    end
    if (cmd.pair_txt) begin
      a_nxt = held_r;
      if (repeat_hit) begin
        b_nxt = IDX_X;
      end else begin
        b_nxt      = kidx;
        held_v_nxt = 1'b0;
      end
    end
    if (cmd.pair_end) begin
      a_nxt      = held_r;
      b_nxt      = IDX_X;
      held_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= 26'd1 << IDX_J;
      fill_r   <= 5'd0;
      walk_r   <= 5'd0;
      held_r   <= 5'd0;
      held_v_r <= 1'b0;
    end else begin
      used_r   <= used_nxt;
      fill_r   <= fill_nxt;
      walk_r   <= walk_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
    end
  end

  assign r1 = row_of(p1_r);
  assign c1 = col_of(p1_r);
  assign r2 = row_of(place_q);
  assign c2 = col_of(place_q);

  always_comb begin
    if (r1 == r2) begin
      q1_nxt = cell_of(r1, step5(c1, decrypt_mode));
      q2_nxt = cell_of(r2, step5(c2, decrypt_mode));
    end else if (c1 == c2) begin
      q1_nxt = cell_of(step5(r1, decrypt_mode), c1);
      q2_nxt = cell_of(step5(r2, decrypt_mode), c2);
    end else begin
      q1_nxt = cell_of(r1, c2);
      q2_nxt = cell_of(r2, c1);
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (cmd.rd_b) begin
      p1_r <= place_q;
    end
    if (cmd.calc) begin
      q1_r <= q1_nxt;
      q2_r <= q2_nxt;
    end
    if (cmd.rd_q2) begin
      l1_r <= sq_q;
    end
    if (cmd.grab_l2) begin
      l2_r <= sq_q;
    end
  end

  assign l_sel  = cmd.sel_l2 ? l2_r : l1_r;
  assign letter = ASCII_A + {2'b00, l_sel};

endmodule
`default_nettype wire

// File: hw/rtl/playfair_digraph_cipher_core.sv
// Top level of the Playfair digraph cipher core.
//
//   Channel  Direction  Contents
//   in_      slave      tuser: action[2:0]; tdata: data_byte[7:0]
//   out_     master     tdata: letter[6:0], zero[7]; tlast: second letter
//   cfg_     write      wr_data: decrypt_mode
//
// Begin-key, key-byte and ignored items are accepted without leaving idle.
// Key done walks the alphabet one letter a cycle.
// A text or end item that completes a pair runs lookup states PA to SC through
// the two RAM read ports, then EM1 and EM2, stretched by out_tready stalls.
// Reset is synchronous, active low, and needs no clearing pass.
`default_nettype none
module playfair_digraph_cipher_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // data_byte[7:0]
  input  wire logic [2:0] in_tuser,   // action[2:0]
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // letter[6:0], zero[7]
  output logic            out_tlast,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);
  import pfc_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [6:0] letter;
  logic       mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  pfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .sts        (sts),
    .cmd        (cmd)
  );

  pfc_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .action       (in_tuser),
    .data_byte    (in_tdata),
    .decrypt_mode (mode_r),
    .cmd          (cmd),
    .sts          (sts),
    .letter       (letter)
  );

  assign out_tdata = {1'b0, letter};

endmodule
`default_nettype wire

// File: hw/rtl/pfc_checker.sv
// Port-level checker for the Playfair cipher core and its bind.
`default_nettype none
module pfc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Output item changed while stalled.");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7] == 1'b0 && out_tdata[6:0] >= 7'd65 && out_tdata[6:0] <= 7'd90)
    else $error("Output item is not an upper-case letter.");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("Second letter of a pair did not follow the first.");

  a_busy_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("Input accepted while a pair is being delivered.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind playfair_digraph_cipher_core pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
